@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("core assertion failed");

// Checks that one condition is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("core sequence assertion failed");

`endif

@@ rtl/core/sbfu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfu_pkg
// Shared types, constants and channel-position tables of the frame unpacker.
// ----------------------------------------------------------------------------
package sbfu_pkg;

	localparam int FrameBytes = 25;
	localparam int ChBits     = 11;
	localparam int PosBits    = 5;

	localparam logic [7:0]         SYNC_RESET = 8'h0f;
	localparam logic [PosBits-1:0] POS_IDLE   = '0;
	localparam logic [PosBits-1:0] POS_LAST   = PosBits'(FrameBytes - 1);

	typedef struct packed {
		logic              has;
		logic              done;
		logic [3:0]        idx;
		logic [ChBits-1:0] val;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] ch;
	} chan_hit_t;

	// Maps the position count reached after a byte to the channel that byte completes.
	function automatic chan_hit_t chan_lookup(input logic [PosBits-1:0] pos);
		chan_hit_t r;
		r.hit = 1'b1;
		r.ch  = 4'd0;
		case (pos)
			5'd3:    r.ch = 4'd0;
			5'd4:    r.ch = 4'd1;
			5'd6:    r.ch = 4'd2;
			5'd7:    r.ch = 4'd3;
			5'd8:    r.ch = 4'd4;
			5'd10:   r.ch = 4'd5;
			5'd11:   r.ch = 4'd6;
			5'd12:   r.ch = 4'd7;
			5'd14:   r.ch = 4'd8;
			5'd15:   r.ch = 4'd9;
			5'd17:   r.ch = 4'd10;
			5'd18:   r.ch = 4'd11;
			5'd19:   r.ch = 4'd12;
			5'd21:   r.ch = 4'd13;
			5'd22:   r.ch = 4'd14;
			5'd23:   r.ch = 4'd15;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// Bit offset of a channel inside the three-byte window ending at its last byte.
	// The pattern repeats every eight channels (eleven bytes).
	function automatic logic [3:0] chan_offset(input logic [2:0] ch_lo);
		logic [3:0] off;
		case (ch_lo)
			3'd0:    off = 4'd8;
			3'd1:    off = 4'd11;
			3'd2:    off = 4'd6;
			3'd3:    off = 4'd9;
			3'd4:    off = 4'd12;
			3'd5:    off = 4'd7;
			3'd6:    off = 4'd10;
			3'd7:    off = 4'd13;
			default: off = 4'd8;
		endcase
		return off;
	endfunction

endpackage

@@ rtl/core/sbfu_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfu_tracker
// Frame position tracking and channel extraction for one beat at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbfu_tracker
	import sbfu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    sync_byte,
	input  logic          valid,
	input  logic          adv,
	input  logic [7:0]    data,
	output result_t       res
);

	logic [PosBits-1:0] pos_q;
	logic [7:0]         prev1_q;
	logic [7:0]         prev2_q;

	logic               take;
	logic               last;
	logic [PosBits-1:0] pos_inc;
	chan_hit_t          hit;
	logic [23:0]        window;

	always_comb begin
		take    = valid && ((pos_q != POS_IDLE) || (data == sync_byte));
		last    = (pos_q == POS_LAST);
		pos_inc = pos_q + PosBits'(1);
		hit     = chan_lookup(pos_inc);
		// The channel that completes now lies in the current byte and the two before it.
		window  = {data, prev1_q, prev2_q};

		res.has  = take && (last || hit.hit);
		res.done = last;
		res.idx  = last ? 4'd0 : hit.ch;
		res.val  = last ? '0 : ChBits'(window >> chan_offset(hit.ch[2:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (adv && take) begin
			pos_q <= last ? POS_IDLE : pos_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			prev2_q <= prev1_q;
			prev1_q <= data;
		end
	end

	`ASSERT_CLK(a_pos_range, clk, arst_n, pos_q <= POS_LAST)
	`ASSERT_NEXT(a_done_to_idle, clk, arst_n, adv && res.has && res.done, pos_q == POS_IDLE)
	`ASSERT_NEXT(a_sync_opens, clk, arst_n, adv && valid && pos_q == POS_IDLE && data == sync_byte,
		pos_q == PosBits'(1))

endmodule

@@ rtl/core/sbus_frame_channel_unpacker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_channel_unpacker_core
// Unpacks the sixteen 11-bit channels of a 25-byte serial bus frame.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on in_valid / in_stall / rx_byte, one byte per beat.
//   While idle, bytes other than the sync byte are dropped. The sync byte opens
//   a 25-byte frame; each channel is sent on out_valid / out_stall as soon as
//   the byte that completes it is in, and the 25th byte yields a beat with
//   frame_done set and zero index and value.
//   cfg_wr_en / cfg_wr_data write the sync byte; write it only while idle.
// Path: a result passes the input register, then the output register; a stalled
//   output can hold it in the input register.
// Throughput: one byte per cycle while in_stall is low, set by the single-pass
//   decode between the input register and the output register.
// Reset: the sync byte returns to 0x0f and the unpacker waits for a sync byte.
// Stall: a held result keeps its beat; the input register keeps draining bytes
//   that give no result, and in_stall rises only when a byte with a result
//   waits behind a stalled output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbus_frame_channel_unpacker_core
	import sbfu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        channel_index,
	output logic [ChBits-1:0] channel_value,
	output logic              frame_done
);

	logic [7:0]        sync_byte_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	logic [3:0]        idx_q;
	logic [ChBits-1:0] val_q;
	logic              done_q;
	logic              adv;
	result_t           res;

	assign adv      = valid_s1 && (!res.has || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	sbfu_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.sync_byte (sync_byte_q),
		.valid     (valid_s1),
		.adv       (adv),
		.data      (byte_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q <= SYNC_RESET;
		end else if (cfg_wr_en) begin
			sync_byte_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.has) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.has) begin
			idx_q  <= res.idx;
			val_q  <= res.val;
			done_q <= res.done;
		end
	end

	assign out_valid     = out_valid_q;
	assign channel_index = idx_q;
	assign channel_value = val_q;
	assign frame_done    = done_q;

	`ASSERT_CLK(a_done_zero, clk, arst_n,
		!(out_valid && frame_done) || (channel_index == 4'd0 && channel_value == '0))
	`ASSERT_CLK(a_stall_needs_item, clk, arst_n, valid_s1 || !in_stall)
	`ASSERT_CLK(a_accept_drains, clk, arst_n, !(in_valid && !in_stall && valid_s1) || adv)

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial bus frame unpacker. A clocked driver
// feeds received bytes from a queue, and a bit-accurate decoder in the bench
// predicts every channel and frame-done beat. A clocked monitor compares each
// output beat with the oldest prediction. Random gaps and stalls are applied
// on both channels, and the sync byte is changed between phases.
// ----------------------------------------------------------------------------
module tb
	import sbfu_pkg::*;
();

	localparam int IdleLimit     = 2000;
	localparam int DrainCycles   = 4;
	localparam int ItemsPerPhase = 285;
	localparam int NumPhases     = 6;

	typedef struct packed {
		logic [3:0]        idx;
		logic [ChBits-1:0] val;
		logic              done;
	} chan_beat_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [7:0]        cfg_wr_data = 8'h00;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [7:0]        rx_byte     = 8'h00;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [3:0]        channel_index;
	logic [ChBits-1:0] channel_value;
	logic              frame_done;

	logic [7:0]   rx_bytes_to_send[$];
	chan_beat_t   channel_beats_due[$];
	logic [7:0]   sync_model;
	logic [4:0]   frame_count;
	logic [7:0]   frame_bytes[FrameBytes];
	logic         no_gaps     = 1'b0;
	int           mismatches  = 0;
	int           send_gap    = 0;
	int           stall_left  = 0;
	int           idle_cycles = 0;

	sbus_frame_channel_unpacker_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.frame_done   (frame_done)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Updates the frame state with one accepted byte and queues the beat it causes.
	task automatic decode_rx_byte(input logic [7:0] b);
		chan_beat_t  beat;
		int          bit0;
		int          first;
		int          last_at;
		logic [23:0] win;
		if (frame_count == POS_IDLE && b != sync_model) begin
			return;
		end
		frame_bytes[frame_count] = b;
		frame_count = frame_count + 5'd1;
		if (frame_count == FrameBytes) begin
			frame_count = POS_IDLE;
			beat.idx  = '0;
			beat.val  = '0;
			beat.done = 1'b1;
			channel_beats_due.push_back(beat);
			return;
		end
		for (int ch = 0; ch < 16; ch++) begin
			last_at = 2 + (ch * ChBits + ChBits - 1) / 8;
			if (last_at == frame_count) begin
				bit0  = ch * ChBits;
				first = 1 + bit0 / 8;
				win   = '0;
				// Only bytes of the current frame are used; later bytes fall outside the mask.
				for (int k = 0; k < 3; k++) begin
					if (first + k < frame_count) begin
						win[8*k +: 8] = frame_bytes[first + k];
					end
				end
				beat.idx  = 4'(ch);
				beat.val  = ChBits'(win >> (bit0 % 8));
				beat.done = 1'b0;
				channel_beats_due.push_back(beat);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_rx_byte(rx_byte);
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (rx_bytes_to_send.size() != 0) begin
					rx_byte  <= rx_bytes_to_send.pop_front();
					in_valid <= 1'b1;
					send_gap = no_gaps ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		chan_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (channel_beats_due.size() == 0) begin
					report_mismatch($sformatf("unexpected beat idx=%0d val=%0d done=%0b",
						channel_index, channel_value, frame_done));
				end else begin
					want = channel_beats_due.pop_front();
					if (channel_index !== want.idx) begin
						report_mismatch($sformatf("channel_index %0d, want %0d",
							channel_index, want.idx));
					end
					if (channel_value !== want.val) begin
						report_mismatch($sformatf("channel_value %0d, want %0d (idx %0d)",
							channel_value, want.val, want.idx));
					end
					if (frame_done !== want.done) begin
						report_mismatch($sformatf("frame_done %0b, want %0b",
							frame_done, want.done));
					end
				end
			end
			if (no_gaps) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IdleLimit) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Waits until every byte is in and every beat is out, then lets the pipeline empty.
	task automatic wait_drained();
		@(negedge clk);
		while (rx_bytes_to_send.size() != 0 || in_valid || channel_beats_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_sync(input logic [7:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sync_model = v;
	endtask

	task automatic close_open_frame();
		if (frame_count != POS_IDLE) begin
			repeat (FrameBytes - frame_count) rx_bytes_to_send.push_back(8'($urandom));
			wait_drained();
		end
	endtask

	// Mostly whole frames with random content; some are cut short to knock the
	// unpacker out of alignment, and noise bytes sit between frames.
	task automatic queue_random_frames(input int quota);
		int         counted;
		int         n;
		int         mode;
		logic [7:0] b;
		counted = 0;
		while (counted < quota) begin
			repeat ($urandom_range(0, 2)) begin
				b = 8'($urandom);
				if (b == sync_model) begin
					b = ~b;
				end
				rx_bytes_to_send.push_back(b);
			end
			mode = $urandom_range(0, 9);
			n = (mode == 9) ? $urandom_range(1, 23) : FrameBytes - 1;
			rx_bytes_to_send.push_back(sync_model);
			for (int i = 0; i < n; i++) begin
				case (mode)
					0:       b = 8'hff;
					1:       b = 8'h00;
					2:       b = ($urandom_range(0, 3) == 0) ? sync_model : 8'($urandom);
					default: b = 8'($urandom);
				endcase
				rx_bytes_to_send.push_back(b);
			end
			counted += n + 1;
		end
	endtask

	initial begin
		logic [7:0] next_sync;
		sync_model  = SYNC_RESET;
		frame_count = POS_IDLE;
		for (int i = 0; i < FrameBytes; i++) begin
			frame_bytes[i] = 8'h00;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Bytes dropped while idle, then one frame: all-ones channels, all-zero
		// channels, a sync value inside the channel data and as the flags byte.
		rx_bytes_to_send.push_back(8'h00);
		rx_bytes_to_send.push_back(8'hff);
		rx_bytes_to_send.push_back(SYNC_RESET);
		for (int i = 1; i < FrameBytes; i++) begin
			if (i <= 11) begin
				rx_bytes_to_send.push_back(8'hff);
			end else if (i == 16 || i == 23) begin
				rx_bytes_to_send.push_back(SYNC_RESET);
			end else if (i == 24) begin
				rx_bytes_to_send.push_back(8'ha5);
			end else begin
				rx_bytes_to_send.push_back(8'h00);
			end
		end
		wait_drained();

		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				0:       next_sync = 8'h00;
				1:       next_sync = 8'hff;
				3:       next_sync = SYNC_RESET;
				default: next_sync = 8'($urandom);
			endcase
			write_sync(next_sync);
			no_gaps = (p == 3);
			queue_random_frames(ItemsPerPhase);
			wait_drained();
			close_open_frame();
		end

		wait_drained();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
